// File: rtl/rppm_pkg.sv
// Shared types, widths and constants for the RC pulse-position decoder.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package rppm_pkg;

  // Channel and stamp widths.
  localparam int NUM_CH    = 7;
  localparam int CH_W      = 16;
  localparam int STAMP_W   = 16;
  localparam int SLOT_W    = 3;
  localparam int IDX_W     = $clog2(NUM_CH);
  // Number of channels latched together and range-checked.
  localparam int NUM_CHECKED = 5;

  // Stream word widths.
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 1;
  localparam int OUT_BITS   = NUM_CH * CH_W + 4;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_NEG_POL = 1'b0;
  localparam logic REG_SINGLE  = 1'b1;

  // Event kinds carried in the input tuser.
  localparam logic EV_CAPTURE = 1'b0;
  localparam logic EV_GAP     = 1'b1;

  // High byte that a valid channel width must carry.
  localparam logic [7:0] CH_HIGH_OK = 8'h01;

  // Configuration handed from the register file to the decoder core.
  typedef struct packed {
    logic neg_pol;
    logic single;
  } cfg_t;

  // One result word as produced by the decoder core.
  typedef struct packed {
    logic                       long_gap;
    logic                       edge_sel;
    logic                       lost;
    logic                       fresh;
    logic [NUM_CH-1:0][CH_W-1:0] chan;
  } result_t;

  // Arithmetic shift right by one on a 16-bit word.
  function automatic logic [CH_W-1:0] sar1(input logic [CH_W-1:0] v);
    sar1 = {v[CH_W-1], v[CH_W-1:1]};
  endfunction

endpackage

`default_nettype wire

// File: rtl/rc_ppm_channel_decoder_top.sv
// Top level of the RC pulse-position decoder: input register, decoder core,
// output stage and configuration registers. Depends on rppm_pkg, rppm_cfg,
// rppm_core and rppm_obuf.
//
//   Channel | Ports  | Word contents (lowest bit up)
//   --------+--------+--------------------------------------------------------
//   input   | in_*   | tdata: stamp[15:0]; tuser: mode (0 capture, 1 gap)
//   result  | out_*  | tdata: seven channels, fresh, lost, edge, long gap, pad
//   config  | cfg_*  | reg 0 negative_polarity @0x0, reg 1 single_train_mode @0x4
//
// One word per cycle is taken and one result word per cycle is given while
// the result sink does not stall; each result word passes from the input register
// through the single subtract-and-check update in the core into the output stage.
// Reset is synchronous and active low; the signal-lost flag comes up set.
// A stalled result sink fills the two-entry output stage before in_tready
// drops, so one result may wait while the next word is still accepted.
`default_nettype none

module rc_ppm_channel_decoder_top (
  input  wire                               clk,
  input  wire                               rst_n,
  // tdata: stamp[15:0]
  input  wire  [rppm_pkg::IN_DATA_W-1:0]    in_tdata,
  // tuser: mode[0]
  input  wire  [rppm_pkg::IN_USER_W-1:0]    in_tuser,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // tdata: chan_one[15:0], chan_two[31:16], chan_three[47:32],
  // chan_four[63:48], chan_five[79:64], chan_six[95:80], chan_seven[111:96],
  // fresh_frame[112], signal_lost[113], edge_select[114],
  // long_gap_armed[115], zero[119:116]
  output logic [rppm_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  input  wire                               cfg_psel,
  input  wire                               cfg_penable,
  input  wire                               cfg_pwrite,
  input  wire  [rppm_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire  [rppm_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [rppm_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  rppm_pkg::cfg_t                    cfg;
  rppm_pkg::result_t                 res;
  logic                              s1_valid_r;
  logic                              s1_mode_r;
  logic [rppm_pkg::STAMP_W-1:0]      s1_stamp_r;
  logic                              ob_full;
  logic                              go;
  logic                              in_acc;
  logic [rppm_pkg::OUT_DATA_W-1:0]   res_word;

  rppm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Input register: a held word moves on once the output stage has room.
  assign go        = s1_valid_r && !ob_full;
  assign in_tready = !s1_valid_r || !ob_full;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r  <= in_tuser[0];
      s1_stamp_r <= in_tdata[rppm_pkg::STAMP_W-1:0];
    end
  end

  rppm_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .mode  (s1_mode_r),
    .stamp (s1_stamp_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Pack the result word, first field in the lowest bits.
  assign res_word = {{(rppm_pkg::OUT_DATA_W - rppm_pkg::OUT_BITS){1'b0}},
                     res.long_gap, res.edge_sel, res.lost, res.fresh, res.chan};

  rppm_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (go),
    .push_data (res_word),
    .full      (ob_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

`default_nettype wire

// File: rtl/rppm_cfg.sv
// Configuration register file with an APB-style write and read port.
// Depends on rppm_pkg for the address width and register indexes.
`default_nettype none

module rppm_cfg (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [rppm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire  [rppm_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rppm_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output rppm_pkg::cfg_t                   cfg
);

  logic neg_pol_r;
  logic single_r;
  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes on the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_pol_r <= 1'b0;
      single_r  <= 1'b0;
    end else if (wr_en) begin
      if (reg_idx == rppm_pkg::REG_NEG_POL) begin
        neg_pol_r <= pwdata[0];
      end else begin
        single_r <= pwdata[0];
      end
    end
  end

  // Read data is the addressed register, zero-extended.
  always_comb begin
    prdata = '0;
    if (reg_idx == rppm_pkg::REG_NEG_POL) begin
      prdata[0] = neg_pol_r;
    end else begin
      prdata[0] = single_r;
    end
  end

  assign cfg.neg_pol = neg_pol_r;
  assign cfg.single  = single_r;

endmodule

`default_nettype wire

// File: rtl/rppm_core.sv
// Decoder state and its update for each event: slot counter, edge, stamps and
// latched channels. Depends on rppm_pkg for widths, types and sar1.
`default_nettype none

module rppm_core (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            go,
  input  wire                            mode,
  input  wire  [rppm_pkg::STAMP_W-1:0]   stamp,
  input  rppm_pkg::cfg_t                 cfg,
  output rppm_pkg::result_t              res
);

  localparam logic [rppm_pkg::SLOT_W-1:0] SLOT_FIRST = '0;
  localparam logic [rppm_pkg::SLOT_W-1:0] SLOT_LATCH = 3'd5;
  localparam logic [rppm_pkg::SLOT_W-1:0] SLOT_CH6   = 3'd6;
  localparam logic [rppm_pkg::SLOT_W-1:0] SLOT_CH7   = 3'd7;
  localparam logic [rppm_pkg::SLOT_W-1:0] SLOT_ONE   = 3'd1;

  logic [rppm_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic                        edge_r, edge_nxt;
  logic                        first_gap_r, first_gap_nxt;
  logic                        fresh_r, fresh_nxt;
  logic                        lost_r, lost_nxt;
  logic                        long_gap_r, long_gap_nxt;
  logic [rppm_pkg::CH_W-1:0]   raw_r   [rppm_pkg::NUM_CH];
  logic [rppm_pkg::CH_W-1:0]   raw_nxt [rppm_pkg::NUM_CH];
  logic [rppm_pkg::CH_W-1:0]   lat_r   [rppm_pkg::NUM_CH];
  logic [rppm_pkg::CH_W-1:0]   lat_nxt [rppm_pkg::NUM_CH];

  logic [rppm_pkg::IDX_W-1:0]  src_idx;
  logic [rppm_pkg::CH_W-1:0]   diff;
  logic [rppm_pkg::CH_W-1:0]   half;

  // The one subtract of the cycle: this stamp against the earlier edge.
  always_comb begin
    if (slot_r == SLOT_CH7) begin
      src_idx = SLOT_CH6;
    end else if (slot_r == SLOT_FIRST) begin
      src_idx = SLOT_FIRST;
    end else begin
      src_idx = slot_r - SLOT_ONE;
    end
    diff = stamp - raw_r[src_idx];
    half = rppm_pkg::sar1(diff);
  end

  // Next-state logic for one event.
  always_comb begin
    logic err;
    logic do_even;
    logic do_odd;
    logic edge_t;
    logic ok;

    err     = 1'b0;
    do_even = 1'b0;
    do_odd  = 1'b0;
    edge_t  = ~edge_r;
    ok      = 1'b1;

    slot_nxt      = slot_r;
    edge_nxt      = edge_r;
    first_gap_nxt = first_gap_r;
    fresh_nxt     = fresh_r;
    lost_nxt      = lost_r;
    long_gap_nxt  = long_gap_r;
    raw_nxt       = raw_r;
    lat_nxt       = lat_r;

    if (go) begin
      if (mode == rppm_pkg::EV_CAPTURE) begin
        first_gap_nxt = 1'b0;
        if (cfg.single) begin
          do_even = !slot_r[0];
          do_odd  = slot_r[0];
        end else begin
          edge_nxt     = edge_t;
          long_gap_nxt = 1'b0;
          // The armed edge decides whether even or odd slots are legal.
          if (cfg.neg_pol ^ edge_t) begin
            do_even = !slot_r[0];
            err     = slot_r[0];
          end else begin
            do_odd = slot_r[0];
            err    = !slot_r[0];
          end
        end
      end else begin
        if (cfg.single) begin
          slot_nxt = SLOT_FIRST;
        end else if (first_gap_r) begin
          long_gap_nxt = 1'b0;
          err          = 1'b1;
        end else begin
          first_gap_nxt = 1'b1;
          long_gap_nxt  = 1'b1;
          slot_nxt      = SLOT_FIRST;
        end
      end
    end

    // Even slot: store the stamp and close the width that ends here.
    if (do_even) begin
      raw_nxt[slot_r[rppm_pkg::IDX_W-1:0]] = stamp;
      if (slot_r == SLOT_CH6) begin
        raw_nxt[SLOT_LATCH] = diff;
        lat_nxt[SLOT_LATCH] = half;
      end else if (slot_r != SLOT_FIRST) begin
        raw_nxt[src_idx] = half;
      end
      slot_nxt = slot_r + SLOT_ONE;
    end

    // Odd slot: channel seven closes the frame, slot five latches the rest.
    if (do_odd) begin
      if (slot_r == SLOT_CH7) begin
        raw_nxt[SLOT_CH6] = diff;
        lat_nxt[SLOT_CH6] = half;
        slot_nxt          = SLOT_FIRST;
      end else begin
        raw_nxt[slot_r[rppm_pkg::IDX_W-1:0]] = stamp;
        raw_nxt[src_idx] = half;
        slot_nxt         = slot_r + SLOT_ONE;
        if (slot_r == SLOT_LATCH) begin
          for (int i = 0; i < rppm_pkg::NUM_CHECKED; i++) begin
            lat_nxt[i] = raw_nxt[i];
            if (raw_nxt[i][rppm_pkg::CH_W-1:8] != rppm_pkg::CH_HIGH_OK) begin
              ok = 1'b0;
            end
          end
          fresh_nxt = 1'b1;
          if (ok) begin
            lost_nxt = 1'b0;
          end else begin
            err = 1'b1;
          end
        end
      end
    end

    // Error restart: drop the frame and, outside single-train mode, re-arm the starting edge.
    if (err) begin
      fresh_nxt = 1'b0;
      lost_nxt  = 1'b1;
      slot_nxt  = SLOT_FIRST;
      if (!cfg.single) begin
        edge_nxt = cfg.neg_pol;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      edge_r      <= 1'b0;
      first_gap_r <= 1'b0;
      fresh_r     <= 1'b0;
      lost_r      <= 1'b1;
      long_gap_r  <= 1'b0;
      for (int i = 0; i < rppm_pkg::NUM_CH; i++) begin
        raw_r[i] <= '0;
        lat_r[i] <= '0;
      end
    end else begin
      slot_r      <= slot_nxt;
      edge_r      <= edge_nxt;
      first_gap_r <= first_gap_nxt;
      fresh_r     <= fresh_nxt;
      lost_r      <= lost_nxt;
      long_gap_r  <= long_gap_nxt;
      raw_r       <= raw_nxt;
      lat_r       <= lat_nxt;
    end
  end

  // The result word shows the state after this event.
  always_comb begin
    for (int i = 0; i < rppm_pkg::NUM_CH; i++) begin
      res.chan[i] = lat_nxt[i];
    end
    res.fresh    = fresh_nxt;
    res.lost     = lost_nxt;
    res.edge_sel = edge_nxt;
    res.long_gap = long_gap_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/rppm_obuf.sv
// Two-entry output stage (main register plus skid register) for results.
// Depends on rppm_pkg for the output word width.
`default_nettype none

module rppm_obuf (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               push,
  input  wire  [rppm_pkg::OUT_DATA_W-1:0]   push_data,
  output logic                              full,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [rppm_pkg::OUT_DATA_W-1:0]   out_data
);

  logic                              main_valid_r;
  logic                              skid_valid_r;
  logic [rppm_pkg::OUT_DATA_W-1:0]   main_data_r;
  logic [rppm_pkg::OUT_DATA_W-1:0]   skid_data_r;
  logic                              pop;

  assign pop       = main_valid_r && out_ready;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;

  // Valid bits: the main slot refills from the skid slot first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop || !main_valid_r) begin
      main_valid_r <= skid_valid_r || push;
      skid_valid_r <= skid_valid_r && push;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload registers follow the same routing.
  always_ff @(posedge clk) begin
    if (pop || !main_valid_r) begin
      if (skid_valid_r) begin
        main_data_r <= skid_data_r;
        if (push) begin
          skid_data_r <= push_data;
        end
      end else if (push) begin
        main_data_r <= push_data;
      end
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rppm_checker.sv
// Port-level checks for the RC pulse-position decoder, bound to its top.
// Depends on rppm_pkg for port widths.
`default_nettype none

module rppm_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_tready,
  input wire [rppm_pkg::OUT_DATA_W-1:0]   out_tdata,
  input wire                              out_tvalid,
  input wire                              out_tready
);

  localparam int FRESH_BIT = rppm_pkg::NUM_CH * rppm_pkg::CH_W;
  localparam int LOST_BIT  = FRESH_BIT + 1;

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // A fresh frame is never reported together with a lost signal.
  a_fresh_lost: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[FRESH_BIT] && out_tdata[LOST_BIT]))
    else $error("fresh frame flagged while signal lost");

  // Input backpressure only once a result is already waiting.
  a_ready_buffer: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  // Reset empties the output stage.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind rc_ppm_channel_decoder_top rppm_checker u_rppm_checker (.*);

`default_nettype wire

// File: tb/sv/tb_rc_ppm_channel_decoder_top.sv
// Self-checking testbench for the RC pulse-position decoder top level.
// Drives capture and gap-timeout words, predicts every result word in a small
// scoreboard class, and depends only on rppm_pkg and rc_ppm_channel_decoder_top.
`default_nettype none

module tb_rc_ppm_channel_decoder_top;

  // Shadow copy of the decoder state; predicts one result word per event.
  class ppm_decoder_shadow;
    bit                        neg_pol;
    bit                        single_mode;
    bit [rppm_pkg::SLOT_W-1:0] slot;
    bit                        edge_bit;
    bit                        gap_seen;
    bit [rppm_pkg::CH_W-1:0]   raw[rppm_pkg::NUM_CH];
    bit [rppm_pkg::CH_W-1:0]   chans[rppm_pkg::NUM_CH];
    bit                        fresh;
    bit                        lost;
    bit                        long_gap;
    rppm_pkg::result_t         outputs_due[$];
    int                        errors;

    function new();
      lost = 1'b1;
    endfunction

    // Arithmetic shift right by one of a wrapped difference.
    function bit [rppm_pkg::CH_W-1:0] half_width(bit [rppm_pkg::CH_W-1:0] d);
      return {d[rppm_pkg::CH_W-1], d[rppm_pkg::CH_W-1:1]};
    endfunction

    // A broken train drops the frame and, outside single-train mode, re-arms the starting edge.
    function void drop_frame();
      fresh = 1'b0;
      lost  = 1'b1;
      slot  = '0;
      if (!single_mode) begin
        edge_bit = neg_pol;
      end
    endfunction

    function void take_even(bit [rppm_pkg::CH_W-1:0] stamp);
      raw[slot] = stamp;
      if (slot == 6) begin
        raw[5]   = raw[6] - raw[5];
        chans[5] = half_width(raw[5]);
      end else if (slot != 0) begin
        raw[slot-1] = half_width(raw[slot] - raw[slot-1]);
      end
      slot = slot + 1'b1;
    endfunction

    function void take_odd(bit [rppm_pkg::CH_W-1:0] stamp);
      bit ok;
      int i;
      if (slot == 7) begin
        // Channel seven closes the frame and the slot count wraps.
        raw[6]   = stamp - raw[6];
        chans[6] = half_width(raw[6]);
        slot     = '0;
        return;
      end
      raw[slot]   = stamp;
      raw[slot-1] = half_width(raw[slot] - raw[slot-1]);
      if (slot == 5) begin
        slot = slot + 1'b1;
        // Channels one to five are latched first, then range-checked.
        ok = 1'b1;
        for (i = 0; i < rppm_pkg::NUM_CHECKED; i++) begin
          chans[i] = raw[i];
          if (raw[i][rppm_pkg::CH_W-1:8] != rppm_pkg::CH_HIGH_OK) begin
            ok = 1'b0;
          end
        end
        fresh = 1'b1;
        if (ok) begin
          lost = 1'b0;
        end else begin
          drop_frame();
        end
      end else begin
        slot = slot + 1'b1;
      end
    endfunction

    // Note an accepted input word and queue the result it must produce.
    function void absorb_event(bit mode, bit [rppm_pkg::STAMP_W-1:0] stamp);
      rppm_pkg::result_t r;
      int i;
      if (mode == rppm_pkg::EV_CAPTURE) begin
        gap_seen = 1'b0;
        if (single_mode) begin
          if (!slot[0]) begin
            take_even(stamp);
          end else begin
            take_odd(stamp);
          end
        end else begin
          edge_bit = ~edge_bit;
          long_gap = 1'b0;
          if (neg_pol ^ edge_bit) begin
            if (!slot[0]) begin
              take_even(stamp);
            end else begin
              drop_frame();
            end
          end else begin
            if (slot[0]) begin
              take_odd(stamp);
            end else begin
              drop_frame();
            end
          end
        end
      end else if (single_mode) begin
        slot = '0;
      end else if (gap_seen) begin
        // A second timeout without any edge means the train is gone.
        long_gap = 1'b0;
        drop_frame();
      end else begin
        gap_seen = 1'b1;
        long_gap = 1'b1;
        slot     = '0;
      end
      for (i = 0; i < rppm_pkg::NUM_CH; i++) begin
        r.chan[i] = chans[i];
      end
      r.fresh    = fresh;
      r.lost     = lost;
      r.edge_sel = edge_bit;
      r.long_gap = long_gap;
      outputs_due.push_back(r);
    endfunction

    function void check_flag(string name, bit exp_val, logic act_val);
      if (act_val !== exp_val) begin
        $error("%s: expected %0d, got %0d", name, exp_val, act_val);
        errors++;
      end
    endfunction

    // Compare an accepted result word with the oldest outstanding one.
    function void compare_result(logic [rppm_pkg::OUT_DATA_W-1:0] word);
      rppm_pkg::result_t e;
      string names[rppm_pkg::NUM_CH];
      int i;
      names = '{"chan_one", "chan_two", "chan_three", "chan_four",
                "chan_five", "chan_six", "chan_seven"};
      if (outputs_due.size() == 0) begin
        $error("result word arrived with no result outstanding");
        errors++;
        return;
      end
      e = outputs_due.pop_front();
      for (i = 0; i < rppm_pkg::NUM_CH; i++) begin
        if (word[rppm_pkg::CH_W*i +: rppm_pkg::CH_W] !== e.chan[i]) begin
          $error("%s: expected %0d, got %0d", names[i],
                 $signed(e.chan[i]), $signed(word[rppm_pkg::CH_W*i +: rppm_pkg::CH_W]));
          errors++;
        end
      end
      check_flag("fresh_frame", e.fresh, word[112]);
      check_flag("signal_lost", e.lost, word[113]);
      check_flag("edge_select", e.edge_sel, word[114]);
      check_flag("long_gap_armed", e.long_gap, word[115]);
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic [rppm_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [rppm_pkg::IN_USER_W-1:0]  in_tuser = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [rppm_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic                            cfg_psel = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite = 1'b0;
  logic [rppm_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [rppm_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [rppm_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  ppm_decoder_shadow sb;
  bit idle_on;
  int words_sent;
  int stall_left;

  rc_ppm_channel_decoder_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watch both channels; input words are noted before results are checked.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.absorb_event(in_tuser[0], in_tdata);
    end
    if (rst_n && out_tvalid && out_tready) begin
      sb.compare_result(out_tdata);
    end
  end

  // Result sink stalls in random bursts while idling is enabled.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Offer one word and hold it until the decoder takes it.
  task automatic send_word(input logic mode,
                           input logic [rppm_pkg::STAMP_W-1:0] stamp);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tuser[0] <= mode;
    in_tdata    <= stamp;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  task automatic apb_write(input logic [rppm_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [rppm_pkg::CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Let every outstanding result drain, then reprogram both registers.
  task automatic set_decoder_mode(input bit neg_pol, input bit single_mode);
    in_tvalid <= 1'b0;
    // Wait first so the last accepted word is already queued.
    @(posedge clk);
    while (sb.outputs_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    apb_write({rppm_pkg::REG_NEG_POL, 2'b00}, {31'd0, neg_pol});
    apb_write({rppm_pkg::REG_SINGLE, 2'b00}, {31'd0, single_mode});
    sb.neg_pol     = neg_pol;
    sb.single_mode = single_mode;
  endtask

  // One train of eight capture words; wild_pct sets the percent of arbitrary spacings.
  task automatic send_train(input int wild_pct);
    logic [rppm_pkg::STAMP_W-1:0] stamp;
    int k;
    stamp = 16'($urandom_range(0, 16'hFFFF));
    for (k = 0; k < 8; k++) begin
      send_word(rppm_pkg::EV_CAPTURE, stamp);
      if ($urandom_range(0, 99) < wild_pct) begin
        stamp = stamp + 16'($urandom_range(0, 16'hFFFF));
      end else begin
        stamp = stamp + 16'($urandom_range(512, 1023));
      end
    end
  endtask

  task automatic run_random(input int n_words, input int quiet_tail);
    int stop_at;
    int pick;
    int k;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      idle_on = (stop_at - words_sent) > quiet_tail;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        // A frame, mostly after a sync gap, the usual shape of a live train.
        if ($urandom_range(0, 3) != 0) begin
          send_word(rppm_pkg::EV_GAP, 16'($urandom_range(0, 16'hFFFF)));
        end
        send_train($urandom_range(0, 3) == 0 ? 15 : 0);
      end else if (pick < 80) begin
        send_word(rppm_pkg::EV_GAP, 16'($urandom_range(0, 16'hFFFF)));
      end else if (pick < 88) begin
        send_word(rppm_pkg::EV_GAP, 16'($urandom_range(0, 16'hFFFF)));
        send_word(rppm_pkg::EV_GAP, 16'($urandom_range(0, 16'hFFFF)));
      end else begin
        for (k = $urandom_range(1, 4); k > 0; k--) begin
          send_word(rppm_pkg::EV_CAPTURE, 16'($urandom_range(0, 16'hFFFF)));
        end
      end
    end
  endtask

  // Directed frames: a good one wrapping the timer, then broken trains.
  task automatic run_directed();
    logic [rppm_pkg::STAMP_W-1:0] stamp;
    logic [rppm_pkg::STAMP_W-1:0] good_steps[8];
    logic [rppm_pkg::STAMP_W-1:0] bad_steps[8];
    int k;
    good_steps = '{16'd512, 16'd1023, 16'd600, 16'd700, 16'd800, 16'd900,
                   16'd1000, 16'd512};
    bad_steps  = '{16'd2, 16'h9000, 16'd1023, 16'd1024, 16'd511, 16'hFFFF,
                   16'd0, 16'd700};
    send_word(rppm_pkg::EV_GAP, 16'hFFFF);
    stamp = 16'hFE00;
    for (k = 0; k < 8; k++) begin
      send_word(rppm_pkg::EV_CAPTURE, stamp);
      stamp = stamp + good_steps[k];
    end
    // Two timeouts in a row declare the signal lost.
    send_word(rppm_pkg::EV_GAP, 16'h0000);
    send_word(rppm_pkg::EV_GAP, 16'h0000);
    stamp = 16'h0000;
    for (k = 0; k < 8; k++) begin
      send_word(rppm_pkg::EV_CAPTURE, stamp);
      stamp = stamp + bad_steps[k];
    end
    // Edges at the wrong parity after a restart.
    send_word(rppm_pkg::EV_GAP, 16'h0000);
    send_word(rppm_pkg::EV_CAPTURE, 16'hFFFF);
    send_word(rppm_pkg::EV_GAP, 16'h0000);
    send_word(rppm_pkg::EV_CAPTURE, 16'h0000);
    send_word(rppm_pkg::EV_CAPTURE, 16'h8000);
    send_word(rppm_pkg::EV_CAPTURE, 16'h7FFF);
  endtask

  initial begin
    sb = new();
    idle_on = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    set_decoder_mode(1'b0, 1'b0);
    run_directed();
    set_decoder_mode(1'b1, 1'b0);
    run_random(350, 0);
    set_decoder_mode(1'b0, 1'b1);
    run_random(300, 0);
    set_decoder_mode(1'b1, 1'b1);
    run_random(300, 0);
    set_decoder_mode(1'b0, 1'b0);
    run_random(550, 200);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outputs_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.outputs_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/rppm_pkg.sv
rtl/rppm_cfg.sv
rtl/rppm_core.sv
rtl/rppm_obuf.sv
rtl/rc_ppm_channel_decoder_top.sv
rtl/rppm_checker.sv
tb/sv/tb_rc_ppm_channel_decoder_top.sv
